FILE: rtl/road_shock_event_classifier_core_macros.svh
// ----------------------------------------------------------------------------
// road_shock_event_classifier_core_macros.svh
// Assertion macros shared by the classifier RTL.
// ----------------------------------------------------------------------------
`ifndef ROAD_SHOCK_EVENT_CLASSIFIER_CORE_MACROS_SVH
`define ROAD_SHOCK_EVENT_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset
`define RSEC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset
`define RSEC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/rsec_pkg.sv
// ----------------------------------------------------------------------------
// rsec_pkg
// Types, register map and constants for the road shock event classifier.
// ----------------------------------------------------------------------------
package rsec_pkg;

   // CSR bus geometry: eight 32-bit registers at 4-byte spacing
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Valid distance window in cm
   localparam logic [15:0] DIST_WIN_LOW  = 16'd5;
   localparam logic [15:0] DIST_WIN_HIGH = 16'd25;

   // Saturation value of the confirm counter
   localparam logic [7:0] CONFIRM_MAX = 8'd255;

   // Register reset values
   localparam logic [15:0] RST_ROUGH_THR     = 16'd400;
   localparam logic [15:0] RST_POTHOLE_THR   = 16'd600;
   localparam logic [15:0] RST_POTHOLE_DIST  = 16'd16;
   localparam logic [15:0] RST_BASELINE_DIST = 16'd15;
   localparam logic [7:0]  RST_CONFIRM       = 8'd2;
   localparam logic [31:0] RST_COOLDOWN      = 32'd1500;
   localparam logic [31:0] RST_INTERVAL      = 32'd2000;
   localparam logic [15:0] RST_CLAMP         = 16'd3000;

   // Register index (byte address / 4)
   typedef enum logic [2:0] {
      REG_ROUGH_THR     = 3'd0,
      REG_POTHOLE_THR   = 3'd1,
      REG_POTHOLE_DIST  = 3'd2,
      REG_BASELINE_DIST = 3'd3,
      REG_CONFIRM       = 3'd4,
      REG_COOLDOWN      = 3'd5,
      REG_INTERVAL      = 3'd6,
      REG_CLAMP         = 3'd7
   } reg_index_type;

   // Road classification codes
   typedef enum logic [1:0] {
      CLASS_NORMAL = 2'd0,
      CLASS_ROUGH  = 2'd1,
      CLASS_HIGH   = 2'd2
   } road_class_type;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [15:0] rough_threshold;
      logic [15:0] pothole_threshold;
      logic [15:0] pothole_distance;
      logic [15:0] baseline_distance;
      logic [7:0]  confirm_needed;
      logic [31:0] cooldown_ms;
      logic [31:0] report_interval_ms;
      logic [15:0] shock_clamp;
   } cfg_type;

   // One input sample
   typedef struct packed {
      logic signed [15:0] shock;
      logic [15:0]        distance_cm;
      logic [31:0]        time_ms;
   } sample_type;

   // One result
   typedef struct packed {
      road_class_type     road_class;
      logic               pothole_event;
      logic               rough_report;
      logic               normal_report;
      logic signed [15:0] shock_echo;
      logic [15:0]        shock_magnitude;
      logic [15:0]        distance_used;
   } result_type;

endpackage

FILE: rtl/rsec_regs.sv
// ----------------------------------------------------------------------------
// rsec_regs
// APB-style configuration register file; zero wait states.
// ----------------------------------------------------------------------------
module rsec_regs
   import rsec_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_en;
   reg_index_type idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign idx        = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   // Write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_ROUGH_THR:     cfg_in.rough_threshold    = csr_pwdata[15:0];
            REG_POTHOLE_THR:   cfg_in.pothole_threshold  = csr_pwdata[15:0];
            REG_POTHOLE_DIST:  cfg_in.pothole_distance   = csr_pwdata[15:0];
            REG_BASELINE_DIST: cfg_in.baseline_distance  = csr_pwdata[15:0];
            REG_CONFIRM:       cfg_in.confirm_needed     = csr_pwdata[7:0];
            REG_COOLDOWN:      cfg_in.cooldown_ms        = csr_pwdata;
            REG_INTERVAL:      cfg_in.report_interval_ms = csr_pwdata;
            REG_CLAMP:         cfg_in.shock_clamp        = csr_pwdata[15:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rough_threshold    <= RST_ROUGH_THR;
         cfg_ff.pothole_threshold  <= RST_POTHOLE_THR;
         cfg_ff.pothole_distance   <= RST_POTHOLE_DIST;
         cfg_ff.baseline_distance  <= RST_BASELINE_DIST;
         cfg_ff.confirm_needed     <= RST_CONFIRM;
         cfg_ff.cooldown_ms        <= RST_COOLDOWN;
         cfg_ff.report_interval_ms <= RST_INTERVAL;
         cfg_ff.shock_clamp        <= RST_CLAMP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux, zero-extended
   always_comb begin
      case (idx)
         REG_ROUGH_THR:     csr_prdata = {16'd0, cfg_ff.rough_threshold};
         REG_POTHOLE_THR:   csr_prdata = {16'd0, cfg_ff.pothole_threshold};
         REG_POTHOLE_DIST:  csr_prdata = {16'd0, cfg_ff.pothole_distance};
         REG_BASELINE_DIST: csr_prdata = {16'd0, cfg_ff.baseline_distance};
         REG_CONFIRM:       csr_prdata = {24'd0, cfg_ff.confirm_needed};
         REG_COOLDOWN:      csr_prdata = cfg_ff.cooldown_ms;
         REG_INTERVAL:      csr_prdata = cfg_ff.report_interval_ms;
         REG_CLAMP:         csr_prdata = {16'd0, cfg_ff.shock_clamp};
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/rsec_eval.sv
// ----------------------------------------------------------------------------
// rsec_eval
// Per-sample evaluation: magnitude, distance substitution, classification,
// pothole confirmation and report rate limiting, plus the history registers.
// ----------------------------------------------------------------------------
module rsec_eval
   import rsec_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  sample_type sample,
   input  logic       advance,
   output result_type result
);

   logic [7:0]  confirm_ff,     confirm_in;
   logic [31:0] last_event_ff,  last_event_in;
   logic [31:0] last_rough_ff,  last_rough_in;
   logic [31:0] last_normal_ff, last_normal_in;

   logic [15:0] raw;
   logic [15:0] mag_abs;
   logic [15:0] mag;
   logic [15:0] dist_used;
   logic        suspect;
   logic [7:0]  confirm_inc;
   logic [31:0] since_event;
   logic [31:0] since_rough;
   logic [31:0] since_normal;
   logic        fire;
   logic        is_rough;
   logic        is_normal;
   logic        rough_rep;
   logic        normal_rep;

   // Magnitude: two's complement negate; 0x8000 stays 0x8000 = 32768
   assign raw     = sample.shock;
   assign mag_abs = raw[15] ? (~raw + 16'd1) : raw;
   assign mag     = (mag_abs > cfg.shock_clamp) ? cfg.shock_clamp : mag_abs;

   // Out-of-window distance replaced by the baseline
   assign dist_used = ((sample.distance_cm < DIST_WIN_LOW) ||
                       (sample.distance_cm > DIST_WIN_HIGH))
                      ? cfg.baseline_distance : sample.distance_cm;

   // Elapsed times, modulo 2^32
   assign since_event  = sample.time_ms - last_event_ff;
   assign since_rough  = sample.time_ms - last_rough_ff;
   assign since_normal = sample.time_ms - last_normal_ff;

   // Pothole confirmation with saturating counter
   assign suspect     = (mag >= cfg.pothole_threshold) && (dist_used >= cfg.pothole_distance);
   assign confirm_inc = (confirm_ff != CONFIRM_MAX) ? (confirm_ff + 8'd1) : confirm_ff;
   assign fire        = suspect && (confirm_inc >= cfg.confirm_needed) &&
                        (since_event > cfg.cooldown_ms);

   // Classification and rate-limited reports
   assign is_rough   = (mag >= cfg.rough_threshold) && (mag < cfg.pothole_threshold);
   assign is_normal  = !is_rough && (mag < cfg.rough_threshold);
   assign rough_rep  = is_rough  && (since_rough  >= cfg.report_interval_ms);
   assign normal_rep = is_normal && (since_normal >= cfg.report_interval_ms);

   // History next values
   always_comb begin
      confirm_in     = confirm_ff;
      last_event_in  = last_event_ff;
      last_rough_in  = last_rough_ff;
      last_normal_in = last_normal_ff;
      if (advance) begin
         confirm_in = (suspect && !fire) ? confirm_inc : 8'd0;
         if (fire) begin
            last_event_in = sample.time_ms;
         end
         if (rough_rep) begin
            last_rough_in = sample.time_ms;
         end
         if (normal_rep) begin
            last_normal_in = sample.time_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         confirm_ff     <= '0;
         last_event_ff  <= '0;
         last_rough_ff  <= '0;
         last_normal_ff <= '0;
      end else begin
         confirm_ff     <= confirm_in;
         last_event_ff  <= last_event_in;
         last_rough_ff  <= last_rough_in;
         last_normal_ff <= last_normal_in;
      end
   end

   // Result assembly
   always_comb begin
      if (is_rough) begin
         result.road_class = CLASS_ROUGH;
      end else if (is_normal) begin
         result.road_class = CLASS_NORMAL;
      end else begin
         result.road_class = CLASS_HIGH;
      end
      result.pothole_event   = fire;
      result.rough_report    = rough_rep;
      result.normal_report   = normal_rep;
      result.shock_echo      = sample.shock;
      result.shock_magnitude = mag;
      result.distance_used   = dist_used;
   end

endmodule

FILE: rtl/road_shock_event_classifier_core.sv
// An accepted sample passes the input register, then the result register, to rsp.
// Throughput: one sample per cycle while rsp_stall is low; the history
// registers update in the same cycle a sample moves into the result register.
// Reset (synchronous): both pipeline registers empty, history cleared to zero,
// configuration registers back to their default values.
// ----------------------------------------------------------------------------
// road_shock_event_classifier_core
// Top level: input register, evaluation datapath, result register, CSRs.
// ----------------------------------------------------------------------------
`include "road_shock_event_classifier_core_macros.svh"

module road_shock_event_classifier_core
   import rsec_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // sample channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic signed [15:0]    req_shock,
   input  logic [15:0]           req_distance_cm,
   input  logic [31:0]           req_time_ms,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_road_class,
   output logic                  rsp_pothole_event,
   output logic                  rsp_rough_report,
   output logic                  rsp_normal_report,
   output logic signed [15:0]    rsp_shock_echo,
   output logic [15:0]           rsp_shock_magnitude,
   output logic [15:0]           rsp_distance_used,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   sample_type sample_ff,    sample_in;
   logic       in_valid_ff,  in_valid_in;
   result_type result;
   result_type result_ff,    result_in;
   logic       out_valid_ff, out_valid_in;
   logic       advance;
   logic       req_take;

   // Configuration registers
   rsec_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Flow control: a sample moves on when the result register is free or drains
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // Input register
   always_comb begin
      sample_in   = sample_ff;
      in_valid_in = in_valid_ff && !advance;
      if (req_take) begin
         sample_in.shock       = req_shock;
         sample_in.distance_cm = req_distance_cm;
         sample_in.time_ms     = req_time_ms;
         in_valid_in           = 1'b1;
      end
   end

   // Evaluation datapath and history
   rsec_eval u_eval (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .sample  (sample_ff),
      .advance (advance),
      .result  (result)
   );

   // Result register
   always_comb begin
      result_in    = result_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      if (advance) begin
         result_in    = result;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      result_ff <= result_in;
   end

   // Output ports
   assign rsp_valid           = out_valid_ff;
   assign rsp_road_class      = result_ff.road_class;
   assign rsp_pothole_event   = result_ff.pothole_event;
   assign rsp_rough_report    = result_ff.rough_report;
   assign rsp_normal_report   = result_ff.normal_report;
   assign rsp_shock_echo      = result_ff.shock_echo;
   assign rsp_shock_magnitude = result_ff.shock_magnitude;
   assign rsp_distance_used   = result_ff.distance_used;

   // Assertions
   `RSEC_ASSERT_IMPL(a_event_not_rough, rsp_valid && rsp_pothole_event, rsp_road_class != CLASS_ROUGH, "pothole event on a sample classed rough")
   `RSEC_ASSERT_IMPL(a_rough_rep_class, rsp_valid && rsp_rough_report, rsp_road_class == CLASS_ROUGH, "rough report on a sample not classed rough")
   `RSEC_ASSERT_IMPL(a_normal_rep_class, rsp_valid && rsp_normal_report, rsp_road_class == CLASS_NORMAL, "normal report on a sample not classed normal")
   `RSEC_ASSERT_NEXT(a_held_sample_kept, in_valid_ff && out_valid_ff && rsp_stall, in_valid_ff && out_valid_ff, "pending sample or result dropped under stall")

endmodule

FILE: verif/rsec_checker.sv
// ----------------------------------------------------------------------------
// rsec_checker
// Scoreboard for the road shock event classifier. Tracks the register
// settings from the CSR port, predicts one result per accepted sample
// transaction and compares every accepted result transaction field by field.
// CSR reads are checked against the tracked register values.
// ----------------------------------------------------------------------------
module rsec_checker
   import rsec_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // sample channel
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic signed [15:0]    req_shock,
   input  logic [15:0]           req_distance_cm,
   input  logic [31:0]           req_time_ms,
   // result channel
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [1:0]            rsp_road_class,
   input  logic                  rsp_pothole_event,
   input  logic                  rsp_rough_report,
   input  logic                  rsp_normal_report,
   input  logic signed [15:0]    rsp_shock_echo,
   input  logic [15:0]           rsp_shock_magnitude,
   input  logic [15:0]           rsp_distance_used,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   // status toward the testbench top
   output int                    fault_count,
   output int                    open_results
);
   timeunit 1ns;
   timeprecision 1ps;

   // Tracked register settings and classifier history
   cfg_type     settings;
   logic [7:0]  suspect_run;
   logic [31:0] last_event_ms;
   logic [31:0] last_rough_ms;
   logic [31:0] last_normal_ms;

   // Predicted results, oldest first
   result_type  road_reports_q[$];
   result_type  head;
   logic [31:0] reg_word;

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      fault_count++;
      if (fault_count <= 10)
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
   endtask

   // Classify one sample and queue the expected result
   task automatic classify_sample(input logic [15:0] shock, input logic [15:0] dist_in,
                                  input logic [31:0] stamp);
      logic [16:0] abs_val;
      logic [15:0] mag;
      logic [15:0] dist_used;
      logic [31:0] since_event;
      logic [31:0] since_rough;
      logic [31:0] since_normal;
      result_type  r;
      // two's complement magnitude; 0x8000 maps to 32768
      abs_val = shock[15] ? (17'h10000 - {1'b0, shock}) : {1'b0, shock};
      mag = (abs_val > {1'b0, settings.shock_clamp}) ? settings.shock_clamp
                                                      : abs_val[15:0];
      dist_used = (dist_in < DIST_WIN_LOW || dist_in > DIST_WIN_HIGH) ?
                  settings.baseline_distance : dist_in;
      since_event  = stamp - last_event_ms;
      since_rough  = stamp - last_rough_ms;
      since_normal = stamp - last_normal_ms;
      r.pothole_event   = 1'b0;
      r.rough_report    = 1'b0;
      r.normal_report   = 1'b0;
      r.shock_echo      = shock;
      r.shock_magnitude = mag;
      r.distance_used   = dist_used;

      // pothole confirmation: saturating run of suspect samples
      if (mag >= settings.pothole_threshold && dist_used >= settings.pothole_distance) begin
         if (suspect_run != CONFIRM_MAX)
            suspect_run++;
         if (suspect_run >= settings.confirm_needed &&
             since_event > settings.cooldown_ms) begin
            last_event_ms   = stamp;
            suspect_run     = '0;
            r.pothole_event = 1'b1;
         end
      end else begin
         suspect_run = '0;
      end

      // road class with rate-limited reports
      if (mag >= settings.rough_threshold && mag < settings.pothole_threshold) begin
         r.road_class = CLASS_ROUGH;
         if (since_rough >= settings.report_interval_ms) begin
            last_rough_ms  = stamp;
            r.rough_report = 1'b1;
         end
      end else if (mag < settings.rough_threshold) begin
         r.road_class = CLASS_NORMAL;
         if (since_normal >= settings.report_interval_ms) begin
            last_normal_ms  = stamp;
            r.normal_report = 1'b1;
         end
      end else begin
         r.road_class = CLASS_HIGH;
      end
      road_reports_q.push_back(r);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         settings.rough_threshold    = RST_ROUGH_THR;
         settings.pothole_threshold  = RST_POTHOLE_THR;
         settings.pothole_distance   = RST_POTHOLE_DIST;
         settings.baseline_distance  = RST_BASELINE_DIST;
         settings.confirm_needed     = RST_CONFIRM;
         settings.cooldown_ms        = RST_COOLDOWN;
         settings.report_interval_ms = RST_INTERVAL;
         settings.shock_clamp        = RST_CLAMP;
         suspect_run    = '0;
         last_event_ms  = '0;
         last_rough_ms  = '0;
         last_normal_ms = '0;
         road_reports_q.delete();
      end else begin
         // CSR read and write transactions
         if (csr_psel && csr_penable && csr_pready) begin
            case (reg_index_type'(csr_paddr[4:2]))
               REG_ROUGH_THR:     reg_word = {16'h0, settings.rough_threshold};
               REG_POTHOLE_THR:   reg_word = {16'h0, settings.pothole_threshold};
               REG_POTHOLE_DIST:  reg_word = {16'h0, settings.pothole_distance};
               REG_BASELINE_DIST: reg_word = {16'h0, settings.baseline_distance};
               REG_CONFIRM:       reg_word = {24'h0, settings.confirm_needed};
               REG_COOLDOWN:      reg_word = settings.cooldown_ms;
               REG_INTERVAL:      reg_word = settings.report_interval_ms;
               default:           reg_word = {16'h0, settings.shock_clamp};
            endcase
            if (!csr_pwrite && csr_prdata !== reg_word)
               flag_mismatch("register readback", reg_word, csr_prdata);
            if (csr_pwrite) begin
               case (reg_index_type'(csr_paddr[4:2]))
                  REG_ROUGH_THR:     settings.rough_threshold = csr_pwdata[15:0];
                  REG_POTHOLE_THR:   settings.pothole_threshold = csr_pwdata[15:0];
                  REG_POTHOLE_DIST:  settings.pothole_distance = csr_pwdata[15:0];
                  REG_BASELINE_DIST: settings.baseline_distance = csr_pwdata[15:0];
                  REG_CONFIRM:       settings.confirm_needed = csr_pwdata[7:0];
                  REG_COOLDOWN:      settings.cooldown_ms = csr_pwdata;
                  REG_INTERVAL:      settings.report_interval_ms = csr_pwdata;
                  default:           settings.shock_clamp = csr_pwdata[15:0];
               endcase
            end
         end

         // result transaction against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (road_reports_q.size() == 0) begin
               flag_mismatch("unrequested result, shock_echo", 32'h0,
                             32'(rsp_shock_echo));
            end else begin
               head = road_reports_q.pop_front();
               if (rsp_road_class !== head.road_class)
                  flag_mismatch("road_class", 32'(head.road_class), 32'(rsp_road_class));
               if (rsp_pothole_event !== head.pothole_event)
                  flag_mismatch("pothole_event", 32'(head.pothole_event),
                                32'(rsp_pothole_event));
               if (rsp_rough_report !== head.rough_report)
                  flag_mismatch("rough_report", 32'(head.rough_report),
                                32'(rsp_rough_report));
               if (rsp_normal_report !== head.normal_report)
                  flag_mismatch("normal_report", 32'(head.normal_report),
                                32'(rsp_normal_report));
               if (rsp_shock_echo !== head.shock_echo)
                  flag_mismatch("shock_echo", 32'(head.shock_echo), 32'(rsp_shock_echo));
               if (rsp_shock_magnitude !== head.shock_magnitude)
                  flag_mismatch("shock_magnitude", 32'(head.shock_magnitude),
                                32'(rsp_shock_magnitude));
               if (rsp_distance_used !== head.distance_used)
                  flag_mismatch("distance_used", 32'(head.distance_used),
                                32'(rsp_distance_used));
            end
         end

         // sample transaction
         if (req_valid && !req_stall)
            classify_sample(req_shock, req_distance_cm, req_time_ms);
      end
      open_results = road_reports_q.size();
   end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the road shock event classifier. Runs directed
// samples at reset settings, then phases of random samples under extreme and
// random register settings, with random gaps and stalls on both channels.
// Checking is done by rsec_checker.
// ----------------------------------------------------------------------------
module tb_top
   import rsec_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid;
   logic                  req_stall;
   logic signed [15:0]    req_shock;
   logic [15:0]           req_distance_cm;
   logic [31:0]           req_time_ms;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [1:0]            rsp_road_class;
   logic                  rsp_pothole_event;
   logic                  rsp_rough_report;
   logic                  rsp_normal_report;
   logic signed [15:0]    rsp_shock_echo;
   logic [15:0]           rsp_shock_magnitude;
   logic [15:0]           rsp_distance_used;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    fault_count;
   int                    open_results;

   // Stimulus-side view of the programmed settings
   cfg_type     settings;
   cfg_type     plan;
   logic [31:0] stamp_ms;
   int          sent_count;
   bit          req_idle;
   bit          rsp_idle;

   road_shock_event_classifier_core u_dut (.*);
   rsec_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard limit on the run
   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   // Result side: random stall before each result transaction
   initial begin
      int hold;
      rsp_stall = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         hold = rsp_idle ? $urandom_range(0, 13) : 0;
         if (hold != 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // One sample transaction, after a random gap
   task automatic send_sample(input logic [15:0] shock, input logic [15:0] distance,
                              input logic [31:0] stamp);
      int gap;
      if (sent_count % 40 == 0) begin
         req_idle = 1'($urandom_range(0, 1));
         rsp_idle = 1'($urandom_range(0, 1));
      end
      sent_count++;
      gap = req_idle ? $urandom_range(0, 13) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_shock       <= shock;
      req_distance_cm <= distance;
      req_time_ms     <= stamp;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // Hold off the sender until every result is back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (open_results != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // One CSR transaction: setup cycle then access cycle
   task automatic csr_access(input reg_index_type idx, input bit write,
                             input logic [31:0] word);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // Read back every register, then release the bus
   task automatic check_registers();
      reg_index_type idx;
      idx = idx.first();
      repeat (idx.num()) begin
         csr_access(idx, 1'b0, 32'h0);
         idx = idx.next();
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic apply_settings(input cfg_type c);
      drain();
      settings = c;
      csr_access(REG_ROUGH_THR,     1'b1, {16'h0, c.rough_threshold});
      csr_access(REG_POTHOLE_THR,   1'b1, {16'h0, c.pothole_threshold});
      csr_access(REG_POTHOLE_DIST,  1'b1, {16'h0, c.pothole_distance});
      csr_access(REG_BASELINE_DIST, 1'b1, {16'h0, c.baseline_distance});
      csr_access(REG_CONFIRM,       1'b1, {24'h0, c.confirm_needed});
      csr_access(REG_COOLDOWN,      1'b1, c.cooldown_ms);
      csr_access(REG_INTERVAL,      1'b1, c.report_interval_ms);
      csr_access(REG_CLAMP,         1'b1, {16'h0, c.shock_clamp});
      check_registers();
   endtask

   // Encode a magnitude as a shock sample of random sign
   function automatic logic [15:0] signed_mag(input int m);
      logic [15:0] v;
      v = (m > 32768) ? 16'h8000 : (m < 0) ? 16'h0 : 16'(m);
      return $urandom_range(0, 1) ? (~v + 16'd1) : v;
   endfunction

   function automatic logic [15:0] near_level(input logic [15:0] level);
      return signed_mag(int'(level) + int'($urandom_range(0, 6)) - 3);
   endfunction

   function automatic logic [15:0] suspect_shock();
      return signed_mag(int'(settings.pothole_threshold) + int'($urandom_range(0, 300)));
   endfunction

   // Deep distance: in the window where possible, else rely on the baseline
   function automatic logic [15:0] suspect_distance();
      logic [15:0] lo;
      if (settings.pothole_distance <= DIST_WIN_HIGH) begin
         lo = (settings.pothole_distance < DIST_WIN_LOW) ? DIST_WIN_LOW
                                                         : settings.pothole_distance;
         return 16'($urandom_range(lo, DIST_WIN_HIGH));
      end
      if (settings.baseline_distance >= settings.pothole_distance)
         return $urandom_range(0, 1) ? 16'($urandom_range(26, 65535))
                                     : 16'($urandom_range(0, 4));
      return 16'($urandom_range(DIST_WIN_LOW, DIST_WIN_HIGH));
   endfunction

   function automatic logic [15:0] plain_shock();
      case ($urandom_range(0, 9))
         0: return near_level(settings.rough_threshold);
         1: return near_level(settings.pothole_threshold);
         2: return near_level(settings.shock_clamp);
         3: begin
            case ($urandom_range(0, 4))
               0: return 16'h0000;
               1: return 16'h7FFF;
               2: return 16'h8000;
               3: return 16'hFFFF;
               default: return 16'h0001;
            endcase
         end
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] plain_distance();
      int v;
      v = $urandom_range(0, 9);
      if (v < 5)
         return 16'($urandom_range(DIST_WIN_LOW, DIST_WIN_HIGH));
      if (v < 7) begin
         // window edges: 4, 5, 25, 26
         v = $urandom_range(0, 3);
         return (v < 2) ? 16'(4 + v) : 16'(23 + v);
      end
      return 16'($urandom);
   endfunction

   task automatic random_item(input bit suspect);
      logic [15:0] shock;
      logic [15:0] distance;
      case ($urandom_range(0, 9))
         0: ;
         1, 2, 3, 4: stamp_ms += $urandom_range(1, 300);
         5, 6, 7: stamp_ms += $urandom_range(300, 4000);
         8: stamp_ms = $urandom;
         default: stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
      endcase
      shock    = suspect ? suspect_shock() : plain_shock();
      distance = suspect ? suspect_distance() : plain_distance();
      send_sample(shock, distance, stamp_ms);
   endtask

   // Mostly runs of suspect samples mixed with single random samples
   task automatic random_phase(input int count);
      int done;
      int run;
      done = 0;
      while (done < count) begin
         if ($urandom_range(0, 9) < 4) begin
            run = $urandom_range(1, 6);
            repeat (run) begin
               random_item(1'b1);
               done++;
            end
         end else begin
            random_item(1'b0);
            done++;
         end
      end
   endtask

   initial begin
      req_valid       = 1'b0;
      req_shock       = '0;
      req_distance_cm = '0;
      req_time_ms     = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      sent_count      = 0;
      settings.rough_threshold    = RST_ROUGH_THR;
      settings.pothole_threshold  = RST_POTHOLE_THR;
      settings.pothole_distance   = RST_POTHOLE_DIST;
      settings.baseline_distance  = RST_BASELINE_DIST;
      settings.confirm_needed     = RST_CONFIRM;
      settings.cooldown_ms        = RST_COOLDOWN;
      settings.report_interval_ms = RST_INTERVAL;
      settings.shock_clamp        = RST_CLAMP;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed samples at reset settings
      check_registers();
      send_sample(16'd0,          16'd15,    32'd0);
      send_sample(16'd399,        16'd5,     32'd2000);
      send_sample(16'd400,        16'd25,    32'd2001);
      send_sample(-16'sd400,      16'd4,     32'd2002);
      send_sample(16'd599,        16'd26,    32'd2003);
      send_sample(16'd600,        16'd16,    32'd2004);
      send_sample(-16'sd600,      16'd20,    32'd2005);   // confirmed event
      send_sample(16'h7FFF,       16'd0,     32'd2006);   // clamped
      send_sample(16'h8000,       16'hFFFF,  32'd2007);   // most negative shock
      send_sample(16'hFFFF,       16'd25,    32'd2008);
      send_sample(16'd1,          16'd5,     32'd4500);
      send_sample(16'd700,        16'd18,    32'd4501);
      send_sample(16'd700,        16'd18,    32'd4502);   // event after cooldown
      send_sample(16'd700,        16'd18,    32'd4503);
      send_sample(16'd700,        16'd18,    32'd4504);   // held off by cooldown
      send_sample(16'd700,        16'd18,    32'd4505);
      send_sample(16'd100,        16'd18,    32'd4506);   // run cleared
      send_sample(16'd3001,       16'd24,    32'hFFFF_FFF0);
      send_sample(-16'sd3000,     16'd24,    32'hFFFF_FFFF);
      send_sample(16'd450,        16'd10,    32'h0000_0005); // time wrap
      send_sample(16'h5555,       16'hAAAA,  32'hAAAA_AAAA);
      send_sample(16'hAAAA,       16'h5555,  32'h5555_5555);
      stamp_ms = 32'h5555_5555;
      random_phase(50);

      // No clamping in effect, everything rough but magnitude 32768 (classed high), every report sent
      plan = '{rough_threshold: 16'd0, pothole_threshold: 16'd32768,
               pothole_distance: 16'd0, baseline_distance: 16'hFFFF,
               confirm_needed: 8'd0, cooldown_ms: 32'd0,
               report_interval_ms: 32'd0, shock_clamp: 16'd32768};
      apply_settings(plan);
      random_phase(50);

      // Rough threshold above pothole threshold, longest timers
      plan = '{rough_threshold: 16'd1000, pothole_threshold: 16'd200,
               pothole_distance: 16'hFFFF, baseline_distance: 16'hFFFF,
               confirm_needed: 8'd1, cooldown_ms: 32'hFFFF_FFFF,
               report_interval_ms: 32'hFFFF_FFFF, shock_clamp: 16'hFFFF};
      apply_settings(plan);
      random_phase(50);

      // Zero clamp: every magnitude is zero
      plan = '{rough_threshold: 16'd32768, pothole_threshold: 16'd0,
               pothole_distance: 16'd20, baseline_distance: 16'd0,
               confirm_needed: 8'd3, cooldown_ms: 32'd100,
               report_interval_ms: 32'd50, shock_clamp: 16'd0};
      apply_settings(plan);
      random_phase(50);

      // Confirm counter saturation: long suspect run that cannot fire
      plan = '{rough_threshold: RST_ROUGH_THR, pothole_threshold: RST_POTHOLE_THR,
               pothole_distance: RST_POTHOLE_DIST, baseline_distance: RST_BASELINE_DIST,
               confirm_needed: 8'd255, cooldown_ms: 32'hFFFF_FFFF,
               report_interval_ms: RST_INTERVAL, shock_clamp: RST_CLAMP};
      apply_settings(plan);
      repeat (262) begin
         stamp_ms += $urandom_range(1, 50);
         send_sample(suspect_shock(), suspect_distance(), stamp_ms);
      end
      plan.cooldown_ms = 32'd0;
      apply_settings(plan);
      repeat (10) begin
         stamp_ms += $urandom_range(1, 50);
         send_sample(suspect_shock(), suspect_distance(), stamp_ms);
      end
      random_phase(40);

      // Random settings
      repeat (3) begin
         plan.rough_threshold    = 16'($urandom_range(0, 1500));
         plan.pothole_threshold  = 16'($urandom_range(0, 2000));
         plan.pothole_distance   = 16'($urandom_range(0, 30));
         plan.baseline_distance  = 16'($urandom_range(0, 30));
         plan.confirm_needed     = 8'($urandom_range(1, 4));
         plan.cooldown_ms        = $urandom_range(0, 3000);
         plan.report_interval_ms = $urandom_range(0, 3000);
         plan.shock_clamp = $urandom_range(0, 1) ? 16'($urandom_range(200, 4000))
                                                 : 16'd32768;
         apply_settings(plan);
         random_phase(50);
      end

      drain();
      repeat (8) @(posedge clock);
      if (fault_count == 0 && open_results == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

FILE: road_shock_event_classifier_core.f
+incdir+rtl
rtl/rsec_pkg.sv
rtl/rsec_regs.sv
rtl/rsec_eval.sv
rtl/road_shock_event_classifier_core.sv
verif/rsec_checker.sv
verif/tb_top.sv
